@@ hw/rtl/tgr_pkg.sv @@
// Package for the typewriter glyph renderer: shared types and codes.
// Used by tgr_seq and typewriter_glyph_renderer. No dependencies.
`default_nettype none

package tgr_pkg;

	localparam int GLYPH_ROWS = 8;
	localparam int PIX_ADDR_W = 13;

	localparam logic [7:0] KEY_NEWLINE   = 8'd13;
	localparam logic [7:0] KEY_BACKSPACE = 8'd8;
	localparam logic [7:0] SPACE_CODE    = 8'd32;

	localparam logic ACT_KEY  = 1'b0;
	localparam logic ACT_FONT = 1'b1;

	localparam logic KIND_ROW   = 1'b0;
	localparam logic KIND_CLEAR = 1'b1;

	typedef enum logic [1:0] {
		CFG_INK   = 2'd0,
		CFG_PAPER = 2'd1,
		CFG_CLEAR = 2'd2
	} cfg_index_t;

	// one result on its way from the sequencer to the output register
	typedef struct packed {
		logic                  valid;
		logic                  kind;
		logic [PIX_ADDR_W-1:0] pixel_address;
		logic [7:0]            glyph_bits;
		logic                  last;
	} out_req_t;

endpackage

`default_nettype wire

@@ hw/rtl/tgr_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module tgr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2048
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/tgr_seq.sv @@
// Key sequencer: cursor, font store, row read issue and read data holding stage.
// Depends on tgr_pkg and tgr_ram.
`default_nettype none

module tgr_seq #(
	parameter int SCREEN_WIDTH  = 128,
	parameter int SCREEN_HEIGHT = 64,
	parameter int GLYPH_COUNT   = 256
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_stall,
	input  wire logic             action,
	input  wire logic [7:0]       key_code,
	input  wire logic [10:0]      font_address,
	input  wire logic [7:0]       font_byte,
	input  wire logic             out_free,
	output tgr_pkg::out_req_t     out_req
);

	localparam int STORE_DEPTH = GLYPH_COUNT * tgr_pkg::GLYPH_ROWS;
	localparam int AW          = $clog2(STORE_DEPTH);
	localparam int CELL_COLS   = SCREEN_WIDTH / 8;
	localparam int CELL_LINES  = SCREEN_HEIGHT / 8;
	localparam int CW          = $clog2(CELL_COLS + 1);
	localparam int LW          = $clog2(CELL_LINES + 1);
	localparam logic [CW-1:0] COLS_W  = CW'(CELL_COLS);
	localparam logic [LW-1:0] LINES_W = LW'(CELL_LINES);
	localparam logic [2:0]    ROW_END = 3'(tgr_pkg::GLYPH_ROWS - 1);

	typedef enum logic [1:0] {
		S_IDLE,
		S_DRAW,
		S_CLEAR
	} state_t;

	state_t state_q;

	logic [CW-1:0] col_q, draw_col_q;
	logic [LW-1:0] line_q, draw_line_q;
	logic [7:0]    code_q;
	logic [2:0]    row_q;
	logic          clr_q;

	logic                           s2_valid_q;
	logic [tgr_pkg::PIX_ADDR_W-1:0] s2_addr_q;
	logic                           s2_blank_q;
	logic                           s2_last_q;

	logic          accept, key_acc, font_wr;
	logic          is_nl, is_bs;
	logic [CW-1:0] dec_col, draw_col_d, col_d;
	logic [LW-1:0] line_d;
	logic [7:0]    code_d;
	logic          clr_d;
	logic          move_s2, slot_free, rd_en, clr_take;
	logic [10:0]   rd_full;
	logic [AW-1:0] rd_addr;
	logic [7:0]    rd_data;
	logic [31:0]   pix_addr;

	tgr_ram #(
		.WIDTH(8),
		.DEPTH(STORE_DEPTH)
	) u_font (
		.clk    (clk),
		.wr_en  (font_wr),
		.wr_addr(font_address[AW-1:0]),
		.wr_data(font_byte),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	always_comb begin
		in_stall = (state_q != S_IDLE);
		accept   = in_valid && !in_stall;
		key_acc  = accept && (action == tgr_pkg::ACT_KEY);
		font_wr  = accept && (action == tgr_pkg::ACT_FONT)
			&& ({1'b0, font_address} < 12'(STORE_DEPTH));

		is_nl = (key_code == tgr_pkg::KEY_NEWLINE);
		is_bs = (key_code == tgr_pkg::KEY_BACKSPACE);

		dec_col    = (col_q == '0) ? '0 : col_q - CW'(1);
		draw_col_d = is_bs ? dec_col : col_q;
		code_d     = is_bs ? tgr_pkg::SPACE_CODE : key_code;

		if (is_nl) begin
			col_d  = '0;
			line_d = line_q + LW'(1);
		end else if (is_bs) begin
			col_d  = dec_col;
			line_d = line_q;
		end else begin
			col_d  = col_q + CW'(1);
			line_d = line_q;
		end
		if (col_d >= COLS_W) begin
			col_d  = '0;
			line_d = line_d + LW'(1);
		end
		clr_d = 1'b0;
		if (line_d >= LINES_W) begin
			col_d  = '0;
			line_d = '0;
			clr_d  = 1'b1;
		end

		move_s2   = s2_valid_q && out_free;
		slot_free = !s2_valid_q || move_s2;
		rd_en     = (state_q == S_DRAW) && slot_free;
		rd_full   = {code_q, row_q};
		rd_addr   = rd_full[AW-1:0];
		clr_take  = (state_q == S_CLEAR) && !s2_valid_q && out_free;

		pix_addr = (32'(draw_line_q) * 32'd8 + 32'(row_q)) * 32'(SCREEN_WIDTH)
			+ 32'(draw_col_q) * 32'd8;

		out_req = '0;
		if (s2_valid_q) begin
			out_req.valid         = 1'b1;
			out_req.kind          = tgr_pkg::KIND_ROW;
			out_req.pixel_address = s2_addr_q;
			out_req.glyph_bits    = s2_blank_q ? 8'd0 : rd_data;
			out_req.last          = s2_last_q;
		end else if (state_q == S_CLEAR) begin
			out_req.valid = 1'b1;
			out_req.kind  = tgr_pkg::KIND_CLEAR;
			out_req.last  = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			col_q       <= '0;
			line_q      <= '0;
			draw_col_q  <= '0;
			draw_line_q <= '0;
			code_q      <= '0;
			row_q       <= '0;
			clr_q       <= 1'b0;
			s2_valid_q  <= 1'b0;
			s2_addr_q   <= '0;
			s2_blank_q  <= 1'b0;
			s2_last_q   <= 1'b0;
		end else begin
			if (rd_en) begin
				s2_valid_q <= 1'b1;
				s2_addr_q  <= pix_addr[tgr_pkg::PIX_ADDR_W-1:0];
				s2_blank_q <= ({1'b0, code_q} >= 9'(GLYPH_COUNT));
				s2_last_q  <= (row_q == ROW_END) && !clr_q;
			end else if (move_s2) begin
				s2_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (key_acc) begin
						col_q       <= col_d;
						line_q      <= line_d;
						draw_col_q  <= draw_col_d;
						draw_line_q <= line_q;
						code_q      <= code_d;
						row_q       <= '0;
						clr_q       <= clr_d;
						if (!is_nl) begin
							state_q <= S_DRAW;
						end else if (clr_d) begin
							state_q <= S_CLEAR;
						end
					end
				end
				S_DRAW: begin
					if (rd_en) begin
						row_q <= row_q + 3'd1;
						if (row_q == ROW_END) begin
							state_q <= clr_q ? S_CLEAR : S_IDLE;
						end
					end
				end
				S_CLEAR: begin
					if (clr_take) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_cursor_in_grid: assert property (@(posedge clk) disable iff (!arst_n)
		(col_q < COLS_W) && (line_q < LINES_W))
		else $error("cursor outside cell grid");

	a_draw_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DRAW) && rd_en && (row_q == ROW_END) |=> (state_q != S_DRAW))
		else $error("draw did not end after last glyph row");

	a_s2_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s2_valid_q && !out_free |=> s2_valid_q && $stable(s2_addr_q) && $stable(rd_data))
		else $error("held row lost while output busy");

	a_clear_after_rows: assert property (@(posedge clk) disable iff (!arst_n)
		clr_take |-> !rd_en && !s2_valid_q)
		else $error("clear issued with a row still outstanding");

endmodule

`default_nettype wire

@@ hw/rtl/typewriter_glyph_renderer.sv @@
// Top level of the typewriter glyph renderer: config registers, output register,
// pixel expansion. Depends on tgr_pkg and tgr_seq.
//
//  channel  direction  handshake              payload
//  in       to block   in_valid / in_stall    action, key_code, font_address, font_byte
//  out      from block out_valid / out_stall  kind, pixel_address, row_pixels, fill_color, last
//  cfg      to block   cfg_valid / cfg_ready  cfg_index, cfg_data
//
// Font write: a single accept. Printable key or backspace: one accept plus 8 row reads,
// one per cycle through the single font RAM read port unless the output stalls. A clear
// waits for the last row to leave the read stage. Newline: a single accept, plus a clear when it wraps.
// Output stalls hold the row read stage.
// Reset clears the cursor and sets config to ink 8, paper 1, clear 8; font RAM contents are undefined until written.
`default_nettype none

module typewriter_glyph_renderer #(
	parameter int SCREEN_WIDTH  = 128,
	parameter int SCREEN_HEIGHT = 64,
	parameter int GLYPH_COUNT   = 256
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        action,
	input  wire logic [7:0]  key_code,
	input  wire logic [10:0] font_address,
	input  wire logic [7:0]  font_byte,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic             kind,
	output logic [12:0]      pixel_address,
	output logic [63:0]      row_pixels,
	output logic [7:0]       fill_color,
	output logic             last,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [7:0]  cfg_data
);

	logic [7:0] ink_q, paper_q, clear_q;

	logic        out_valid_q, kind_q, last_q;
	logic [12:0] addr_q;
	logic [63:0] pix_q;
	logic [7:0]  fill_q;

	tgr_pkg::out_req_t req;
	logic              out_free;
	logic [63:0]       pix_d;

	tgr_seq #(
		.SCREEN_WIDTH (SCREEN_WIDTH),
		.SCREEN_HEIGHT(SCREEN_HEIGHT),
		.GLYPH_COUNT  (GLYPH_COUNT)
	) u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.action      (action),
		.key_code    (key_code),
		.font_address(font_address),
		.font_byte   (font_byte),
		.out_free    (out_free),
		.out_req     (req)
	);

	assign cfg_ready = 1'b1;
	assign out_free  = !out_valid_q || !out_stall;

	always_comb begin
		for (int i = 0; i < 8; i++) begin
			pix_d[63 - 8 * i -: 8] = req.glyph_bits[7 - i] ? ink_q : paper_q;
		end
		if (req.kind == tgr_pkg::KIND_CLEAR) begin
			pix_d = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ink_q   <= 8'd8;
			paper_q <= 8'd1;
			clear_q <= 8'd8;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				tgr_pkg::CFG_INK:   ink_q   <= cfg_data;
				tgr_pkg::CFG_PAPER: paper_q <= cfg_data;
				tgr_pkg::CFG_CLEAR: clear_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			kind_q      <= 1'b0;
			addr_q      <= '0;
			pix_q       <= '0;
			fill_q      <= '0;
			last_q      <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= req.valid;
			if (req.valid) begin
				kind_q <= req.kind;
				addr_q <= req.pixel_address;
				pix_q  <= pix_d;
				fill_q <= (req.kind == tgr_pkg::KIND_CLEAR) ? clear_q : 8'd0;
				last_q <= req.last;
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign kind          = kind_q;
	assign pixel_address = addr_q;
	assign row_pixels    = pix_q;
	assign fill_color    = fill_q;
	assign last          = last_q;

endmodule

`default_nettype wire
